// ===== hw/rtl/uv_sphere_mesh_generator_unit_defines.svh =====
// ---------------------------------------------------------------------------
// uv sphere mesh generator assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define USMG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("usmg assertion failed");

// next-cycle implication
`define USMG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("usmg assertion failed");

`endif

// ===== hw/rtl/usmg_pkg.sv =====
// ---------------------------------------------------------------------------
// usmg package
// widths, latencies, types and helper functions of the sphere mesh unit
// ---------------------------------------------------------------------------
package usmg_pkg;

   localparam int INDEX_W        = 8;
   localparam int VIDX_W         = 16;
   localparam int POS_W          = 17;
   localparam int NORM_W         = 16;
   localparam int TEX_W          = 17;
   localparam int RADIUS_W       = 16;
   localparam int PHASE_W        = 16;

   localparam int DIV_NUM_W      = 25;
   localparam int DIV_DEN_W      = 9;
   localparam int DIV_STEPS      = 5;
   localparam int DIV_STAGES     = DIV_NUM_W / DIV_STEPS;

   localparam int CORDIC_ITERS   = 16;
   localparam int CORDIC_STEPS   = 2;
   localparam int CORDIC_STAGES  = CORDIC_ITERS / CORDIC_STEPS;
   localparam int CORDIC_LAT     = CORDIC_STAGES + 1;
   localparam int CORDIC_XY_W    = 32;
   localparam int CORDIC_Z_W     = 26;
   localparam logic signed [CORDIC_XY_W-1:0] CORDIC_X0 = 32'sd163008219;

   localparam int SHADE_STAGES   = 2;
   localparam int TEX_LAT        = CORDIC_LAT + SHADE_STAGES;
   localparam int TOTAL_LAT      = DIV_STAGES + TEX_LAT;

   localparam logic [TEX_W-1:0]  TEX_ONE  = 17'd65536;
   localparam logic signed [NORM_W-1:0] UNIT_Q14 = 16'sd16384;

   typedef enum logic [1:0] {
      QUAD_EAST  = 2'd0,
      QUAD_NORTH = 2'd1,
      QUAD_WEST  = 2'd2,
      QUAD_SOUTH = 2'd3
   } quad_type;

   typedef enum logic [1:0] {
      CSR_RADIUS      = 2'd0,
      CSR_SLICE_COUNT = 2'd1,
      CSR_STACK_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [CORDIC_XY_W-1:0] x;
      logic signed [CORDIC_XY_W-1:0] y;
      logic signed [CORDIC_Z_W-1:0]  z;
      quad_type                      quad;
   } cordic_vec_type;

   typedef struct packed {
      logic [VIDX_W-1:0] corner_a;
      logic [VIDX_W-1:0] corner_b;
      logic [VIDX_W-1:0] corner_c;
      logic              valid;
   } tri_type;

   typedef struct packed {
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
   } tex_type;

   // arctangent table, 2^-24 turn
   function automatic logic signed [CORDIC_Z_W-1:0] cordic_angle(input int k);
      case (k)
         0:       cordic_angle = 26'sd2097152;
         1:       cordic_angle = 26'sd1238021;
         2:       cordic_angle = 26'sd654136;
         3:       cordic_angle = 26'sd332050;
         4:       cordic_angle = 26'sd166669;
         5:       cordic_angle = 26'sd83416;
         6:       cordic_angle = 26'sd41718;
         7:       cordic_angle = 26'sd20860;
         8:       cordic_angle = 26'sd10430;
         9:       cordic_angle = 26'sd5215;
         10:      cordic_angle = 26'sd2608;
         11:      cordic_angle = 26'sd1304;
         12:      cordic_angle = 26'sd652;
         13:      cordic_angle = 26'sd326;
         14:      cordic_angle = 26'sd163;
         15:      cordic_angle = 26'sd81;
         default: cordic_angle = 26'sd0;
      endcase
   endfunction

   // q2.28 to q1.14, round half up, clamp to plus or minus one
   function automatic logic signed [NORM_W-1:0] round_clamp_q14(
      input logic signed [CORDIC_XY_W-1:0] v);
      logic signed [CORDIC_XY_W-1:0] t;
      t = (v + 32'sd8192) >>> 14;
      if (t > 32'sd16384) begin
         round_clamp_q14 = UNIT_Q14;
      end else if (t < -32'sd16384) begin
         round_clamp_q14 = -UNIT_Q14;
      end else begin
         round_clamp_q14 = t[NORM_W-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/usmg_divider.sv =====
// ---------------------------------------------------------------------------
// usmg divider
// pipelined restoring divider, several quotient bits per stage
// ---------------------------------------------------------------------------
module usmg_divider import usmg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [DIV_NUM_W-1:0] in_num,
   input  logic [DIV_DEN_W-1:0] in_den,
   output logic                 out_valid,
   output logic [DIV_NUM_W-1:0] out_quo
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_NUM_W-1:0]  work_ff [DIV_STAGES];
   logic [DIV_NUM_W-1:0]  work_in [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  rem_ff  [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  rem_in  [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  den_ff  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [DIV_NUM_W-1:0] work_src;
      logic [DIV_DEN_W-1:0] rem_src;
      logic [DIV_DEN_W-1:0] den_src;

      if (s == 0) begin : g_first
         assign work_src = in_num;
         assign rem_src  = '0;
         assign den_src  = in_den;
      end else begin : g_next
         assign work_src = work_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
      end

      // shifted-in quotient bits replace numerator bits from the bottom
      always_comb begin : p_steps
         logic [DIV_NUM_W-1:0] w;
         logic [DIV_DEN_W-1:0] r;
         logic [DIV_DEN_W:0]   t;
         w = work_src;
         r = rem_src;
         for (int n = 0; n < DIV_STEPS; n++) begin
            t = {r, w[DIV_NUM_W-1]};
            w = {w[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, den_src}) begin
               t    = t - {1'b0, den_src};
               w[0] = 1'b1;
            end
            r = t[DIV_DEN_W-1:0];
         end
         work_in[s] = w;
         rem_in[s]  = r;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            work_ff[s] <= work_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quo   = work_ff[DIV_STAGES-1];

endmodule

// ===== hw/rtl/usmg_cordic.sv =====
// ---------------------------------------------------------------------------
// usmg cordic
// pipelined rotation cordic, phase in 2^-16 turn to sine and cosine q1.14
// ---------------------------------------------------------------------------
module usmg_cordic import usmg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic [PHASE_W-1:0]       in_phase,
   output logic                     out_valid,
   output logic signed [NORM_W-1:0] out_sin,
   output logic signed [NORM_W-1:0] out_cos
);

   logic [CORDIC_STAGES-1:0] valid_ff;
   cordic_vec_type           vec_ff [CORDIC_STAGES];
   cordic_vec_type           vec_in [CORDIC_STAGES];
   cordic_vec_type           start_vec;
   logic                     done_valid_ff;
   logic signed [NORM_W-1:0] sin_ff;
   logic signed [NORM_W-1:0] cos_ff;
   logic signed [NORM_W-1:0] sin_in;
   logic signed [NORM_W-1:0] cos_in;

   // fold the phase to within an eighth turn of the nearest quadrant
   always_comb begin : p_fold
      logic [PHASE_W-1:0] sum;
      logic [PHASE_W-1:0] res;
      sum = in_phase + 16'h2000;
      res = in_phase - {sum[15:14], 14'd0};
      start_vec.quad = quad_type'(sum[15:14]);
      start_vec.x    = CORDIC_X0;
      start_vec.y    = '0;
      start_vec.z    = {{(CORDIC_Z_W-24){res[15]}}, res, 8'd0};
   end

   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
      cordic_vec_type src;

      if (s == 0) begin : g_first
         assign src = start_vec;
      end else begin : g_next
         assign src = vec_ff[s-1];
      end

      always_comb begin : p_rotate
         cordic_vec_type v;
         logic signed [CORDIC_XY_W-1:0] xs;
         logic signed [CORDIC_XY_W-1:0] ys;
         v = src;
         for (int n = 0; n < CORDIC_STEPS; n++) begin
            xs = v.x >>> (s * CORDIC_STEPS + n);
            ys = v.y >>> (s * CORDIC_STEPS + n);
            if (!v.z[CORDIC_Z_W-1]) begin
               v.x = v.x - ys;
               v.y = v.y + xs;
               v.z = v.z - cordic_angle(s * CORDIC_STEPS + n);
            end else begin
               v.x = v.x + ys;
               v.y = v.y - xs;
               v.z = v.z + cordic_angle(s * CORDIC_STEPS + n);
            end
         end
         vec_in[s] = v;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            vec_ff[s] <= vec_in[s];
         end
      end
   end

   // unfold the quadrant and round
   always_comb begin
      cordic_vec_type v;
      v = vec_ff[CORDIC_STAGES-1];
      case (v.quad)
         QUAD_EAST: begin
            cos_in = round_clamp_q14(v.x);
            sin_in = round_clamp_q14(v.y);
         end
         QUAD_NORTH: begin
            cos_in = round_clamp_q14(-v.y);
            sin_in = round_clamp_q14(v.x);
         end
         QUAD_WEST: begin
            cos_in = round_clamp_q14(-v.x);
            sin_in = round_clamp_q14(-v.y);
         end
         default: begin
            cos_in = round_clamp_q14(v.y);
            sin_in = round_clamp_q14(-v.x);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         done_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff      <= {valid_ff[CORDIC_STAGES-2:0], in_valid};
         done_valid_ff <= valid_ff[CORDIC_STAGES-1];
      end
   end

   assign out_valid = done_valid_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

endmodule

// ===== hw/rtl/usmg_shade.sv =====
// ---------------------------------------------------------------------------
// usmg shade
// normal from the two angle pairs, then position as radius times normal
// ---------------------------------------------------------------------------
module usmg_shade import usmg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic signed [NORM_W-1:0] sin_theta,
   input  logic signed [NORM_W-1:0] cos_theta,
   input  logic signed [NORM_W-1:0] sin_phi,
   input  logic signed [NORM_W-1:0] cos_phi,
   input  logic [RADIUS_W-1:0]      radius,
   output logic                     out_valid,
   output logic signed [NORM_W-1:0] norm_x,
   output logic signed [NORM_W-1:0] norm_y,
   output logic signed [NORM_W-1:0] norm_z,
   output logic signed [POS_W-1:0]  pos_x,
   output logic signed [POS_W-1:0]  pos_y,
   output logic signed [POS_W-1:0]  pos_z
);

   localparam int PROD_W = RADIUS_W + 1 + NORM_W + 1;

   logic [SHADE_STAGES-1:0]          valid_ff;
   logic signed [NORM_W-1:0]         nx_ff, ny_ff, nz_ff;
   logic signed [NORM_W-1:0]         nx_in, ny_in;
   logic signed [NORM_W-1:0]         nx2_ff, ny2_ff, nz2_ff;
   logic signed [POS_W-1:0]          px_ff, py_ff, pz_ff;
   logic signed [POS_W-1:0]          px_in, py_in, pz_in;
   logic signed [CORDIC_XY_W-1:0]    prod_x, prod_y;
   logic signed [PROD_W-1:0]         rad_s;

   assign prod_x = sin_phi * cos_theta;
   assign prod_y = sin_phi * sin_theta;
   assign nx_in  = round_clamp_q14(prod_x);
   assign ny_in  = round_clamp_q14(prod_y);

   assign rad_s = $signed({{(PROD_W-RADIUS_W){1'b0}}, radius});

   always_comb begin : p_scale
      logic signed [PROD_W-1:0] tx, ty, tz;
      tx = (rad_s * PROD_W'(nx_ff) + PROD_W'(8192)) >>> 14;
      ty = (rad_s * PROD_W'(ny_ff) + PROD_W'(8192)) >>> 14;
      tz = (rad_s * PROD_W'(nz_ff) + PROD_W'(8192)) >>> 14;
      px_in = tx[POS_W-1:0];
      py_in = ty[POS_W-1:0];
      pz_in = tz[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         nz_ff  <= cos_phi;
         nx2_ff <= nx_ff;
         ny2_ff <= ny_ff;
         nz2_ff <= nz_ff;
         px_ff  <= px_in;
         py_ff  <= py_in;
         pz_ff  <= pz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[SHADE_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[SHADE_STAGES-1];
   assign norm_x    = nx2_ff;
   assign norm_y    = ny2_ff;
   assign norm_z    = nz2_ff;
   assign pos_x     = px_ff;
   assign pos_y     = py_ff;
   assign pos_z     = pz_ff;

endmodule

// ===== hw/rtl/uv_sphere_mesh_generator_unit.sv =====
// ---------------------------------------------------------------------------
// uv sphere mesh generator unit
// grid request to vertex, normal, texture coordinate and triangle indices
// ---------------------------------------------------------------------------
// Each request (slice i, stack j, half h) returns one result: the vertex at
// theta = 2*pi*i/slices and phi = pi*j/stacks with position, normal and u/v,
// plus triangle h of cell (i,j) as three vertex indices. The unit takes one
// transfer per cycle; the pipeline is 5 stages of a restoring divider (5
// quotient bits a stage) for the angles and u/v, 9 stages of a 16-iteration
// cordic (2 iterations a stage plus a rounding stage) and 2 multiply stages
// for normal and position. A stalled result freezes the whole pipeline, so
// req_tready follows rsp_tready while a result is waiting. Registers must
// be written only while the unit is idle; the unit does not enforce this.
// ---------------------------------------------------------------------------
`include "uv_sphere_mesh_generator_unit_defines.svh"

module uv_sphere_mesh_generator_unit import usmg_pkg::*; #(
   parameter int GRID_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   // configuration
   input  logic          csr_wen,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   // request: slice_index [7:0], stack_index [15:8]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,
   // request: which_half [0]
   input  logic [0:0]    req_tuser,
   // result: pos_x [16:0], pos_y [33:17], pos_z [50:34], norm_x [66:51],
   // norm_y [82:67], norm_z [98:83], tex_u [115:99], tex_v [132:116],
   // corner_a [148:133], corner_b [164:149], corner_c [180:165], zero pad
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [183:0]  rsp_tdata,
   // result: tri_valid [0]
   output logic [0:0]    rsp_tuser
);

   localparam logic [INDEX_W-1:0] GRID_MASK = INDEX_W'((1 << GRID_BITS) - 1);

   // configuration registers
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [INDEX_W-1:0]  slices_ff, slices_in;
   logic [INDEX_W-1:0]  stacks_ff, stacks_in;

   // pipeline control
   logic                enable;

   // request decode
   logic [INDEX_W-1:0]  idx_i, idx_j, ns, nt;
   logic                half;
   tri_type             tri_in;

   // divider results
   logic                div_u_valid, div_v_valid, div_p_valid;
   logic [DIV_NUM_W-1:0] quo_u, quo_v, quo_p;
   tex_type             tex_in;

   // cordic results
   logic                cth_valid, cph_valid;
   logic signed [NORM_W-1:0] sin_t, cos_t, sin_p, cos_p;

   // shading results
   logic                shade_valid;
   logic signed [NORM_W-1:0] n_x, n_y, n_z;
   logic signed [POS_W-1:0]  p_x, p_y, p_z;

   // side data delay lines
   tri_type             tri_ff [TOTAL_LAT];
   tex_type             tex_ff [TEX_LAT];

   // register writes, a write to an unused index is dropped
   always_comb begin
      radius_in = radius_ff;
      slices_in = slices_ff;
      stacks_in = stacks_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_RADIUS:      radius_in = csr_wdata;
            CSR_SLICE_COUNT: slices_in = csr_wdata[INDEX_W-1:0];
            CSR_STACK_COUNT: stacks_in = csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         slices_ff <= 8'd32;
         stacks_ff <= 8'd16;
      end else begin
         radius_ff <= radius_in;
         slices_ff <= slices_in;
         stacks_ff <= stacks_in;
      end
   end

   // whole pipeline advances unless a result is held at the output
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // grid wrap and zero count acting as one
   always_comb begin
      idx_i = req_tdata[7:0] & GRID_MASK;
      idx_j = req_tdata[15:8] & GRID_MASK;
      half  = req_tuser[0];
      ns    = slices_ff & GRID_MASK;
      nt    = stacks_ff & GRID_MASK;
      if (ns == '0) begin
         ns = INDEX_W'(1);
      end
      if (nt == '0) begin
         nt = INDEX_W'(1);
      end
   end

   // triangle of the cell, polar rows have only the first half
   always_comb begin : p_tri
      logic [INDEX_W:0]    row;
      logic [VIDX_W-1:0]   prod;
      logic [VIDX_W-1:0]   s0, s1, jx;
      row    = {1'b0, nt} + 9'd1;
      prod   = {{(VIDX_W-INDEX_W){1'b0}}, idx_i}
               * {{(VIDX_W-INDEX_W-1){1'b0}}, row};
      s0     = prod;
      s1     = s0 + {{(VIDX_W-INDEX_W-1){1'b0}}, row};
      jx     = {{(VIDX_W-INDEX_W){1'b0}}, idx_j};
      tri_in = '0;
      if (idx_i < ns && idx_j < nt) begin
         if (idx_j == '0) begin
            if (!half) begin
               tri_in = '{corner_a: s0, corner_b: s0 + 16'd1, corner_c: s1 + 16'd1,
                          valid: 1'b1};
            end
         end else if (idx_j == nt - 8'd1) begin
            if (!half) begin
               tri_in = '{corner_a: s0 + jx, corner_b: s0 + jx + 16'd1,
                          corner_c: s1 + jx, valid: 1'b1};
            end
         end else if (!half) begin
            tri_in = '{corner_a: s0 + jx, corner_b: s0 + jx + 16'd1,
                       corner_c: s1 + jx + 16'd1, valid: 1'b1};
         end else begin
            tri_in = '{corner_a: s1 + jx, corner_b: s0 + jx,
                       corner_c: s1 + jx + 16'd1, valid: 1'b1};
         end
      end
   end

   // u and theta share one quotient, v and phi need their own
   usmg_divider u_div_u (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .in_num    ({idx_i, 17'd0} + {17'd0, ns}),
      .in_den    ({ns, 1'b0}),
      .out_valid (div_u_valid),
      .out_quo   (quo_u)
   );

   usmg_divider u_div_v (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .in_num    ({idx_j, 17'd0} + {17'd0, nt}),
      .in_den    ({nt, 1'b0}),
      .out_valid (div_v_valid),
      .out_quo   (quo_v)
   );

   usmg_divider u_div_p (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_tvalid),
      .in_num    ({1'b0, idx_j, 16'd0} + {17'd0, nt}),
      .in_den    ({nt, 1'b0}),
      .out_valid (div_p_valid),
      .out_quo   (quo_p)
   );

   // texture coordinates saturate at one beyond the grid
   always_comb begin
      tex_in.u = (quo_u > {{(DIV_NUM_W-TEX_W){1'b0}}, TEX_ONE}) ? TEX_ONE : quo_u[TEX_W-1:0];
      tex_in.v = (quo_v > {{(DIV_NUM_W-TEX_W){1'b0}}, TEX_ONE}) ? TEX_ONE : quo_v[TEX_W-1:0];
   end

   usmg_cordic u_cordic_theta (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (div_u_valid),
      .in_phase  (quo_u[PHASE_W-1:0]),
      .out_valid (cth_valid),
      .out_sin   (sin_t),
      .out_cos   (cos_t)
   );

   usmg_cordic u_cordic_phi (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (div_p_valid && div_v_valid),
      .in_phase  (quo_p[PHASE_W-1:0]),
      .out_valid (cph_valid),
      .out_sin   (sin_p),
      .out_cos   (cos_p)
   );

   usmg_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (cth_valid && cph_valid),
      .sin_theta (sin_t),
      .cos_theta (cos_t),
      .sin_phi   (sin_p),
      .cos_phi   (cos_p),
      .radius    (radius_ff),
      .out_valid (shade_valid),
      .norm_x    (n_x),
      .norm_y    (n_y),
      .norm_z    (n_z),
      .pos_x     (p_x),
      .pos_y     (p_y),
      .pos_z     (p_z)
   );

   // side data follows the arithmetic pipeline in lockstep
   always_ff @(posedge clock) begin
      if (enable) begin
         tri_ff[0] <= tri_in;
         for (int k = 1; k < TOTAL_LAT; k++) begin
            tri_ff[k] <= tri_ff[k-1];
         end
         tex_ff[0] <= tex_in;
         for (int k = 1; k < TEX_LAT; k++) begin
            tex_ff[k] <= tex_ff[k-1];
         end
      end
   end

   assign rsp_tvalid = shade_valid;
   assign rsp_tdata  = {3'd0,
                        tri_ff[TOTAL_LAT-1].corner_c,
                        tri_ff[TOTAL_LAT-1].corner_b,
                        tri_ff[TOTAL_LAT-1].corner_a,
                        tex_ff[TEX_LAT-1].v,
                        tex_ff[TEX_LAT-1].u,
                        n_z, n_y, n_x,
                        p_z, p_y, p_x};
   assign rsp_tuser  = tri_ff[TOTAL_LAT-1].valid;

   // a held result must block new transfers
   `USMG_ASSERT_IMPL(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // missing triangles carry zero corners
   `USMG_ASSERT_IMPL(a_tri_zero, clock, reset, rsp_tvalid && !rsp_tuser[0],
                     rsp_tdata[180:133] == 48'd0)
   // u never passes one
   `USMG_ASSERT_IMPL(a_tex_sat, clock, reset, rsp_tvalid, rsp_tdata[115:99] <= TEX_ONE)
   // nothing leaves the pipe right after reset
   `USMG_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule
